// ===== hw/rtl/triple_sha256_nonce_check_assert.svh =====
// Assertion macros for the nonce check block
`ifndef TRIPLE_SHA256_NONCE_CHECK_ASSERT_SVH
`define TRIPLE_SHA256_NONCE_CHECK_ASSERT_SVH
`define TSN_ASSERT_IMP(label, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define TSN_ASSERT_NXT(label, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

// ===== hw/rtl/tsn_pkg.sv =====
// ----------------------------------------------------------------------------
// tsn_pkg
// Types, constants and SHA-256 helpers for the nonce check block.
// ----------------------------------------------------------------------------
`default_nettype none
package tsn_pkg;
	localparam int HdrWords = 19;
	localparam int TgtWords = 8;

	typedef enum logic [1:0] {
		OP_LOAD_HDR = 2'd0,
		OP_LOAD_TGT = 2'd1,
		OP_HASH     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	localparam logic [1:0] RegBench = 2'd0;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  word_index;
		logic [31:0] word_value;
		logic [31:0] nonce;
	} in_item_t;

	typedef struct packed {
		logic        meets_target;
		logic [31:0] nonce_echo;
		logic [63:0] hash_low_pair;
		logic [63:0] hash_second_pair;
		logic [63:0] hash_third_pair;
		logic [63:0] hash_high_pair;
	} out_item_t;

	// control between sequencer and round core
	typedef struct packed {
		logic       init;   // load chain from chain_in, working vars too
		logic       round;  // run one round
		logic       finish; // add working vars into chain
		logic [5:0] rnd;
	} core_ctl_t;

	localparam logic [255:0] Iv = {
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

	localparam logic [31:0] PadWord = 32'h80000000;
	localparam logic [31:0] Len80 = 32'(80 * 8);
	localparam logic [31:0] Len32 = 32'(32 * 8);

	function automatic logic [31:0] k_round(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/tsn_stream_if.sv =====
// ----------------------------------------------------------------------------
// tsn_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsn_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tsn_round_core.sv =====
// ----------------------------------------------------------------------------
// tsn_round_core
// One SHA-256 round per cycle with a rolling 16-word schedule window.
// ----------------------------------------------------------------------------
`default_nettype none
module tsn_round_core (
	input  wire                 clk,
	input  tsn_pkg::core_ctl_t  ctl,
	input  wire  [255:0]        chain_in,
	input  wire  [511:0]        block_in,
	output logic [255:0]        chain_out
);
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [31:0] s0, s1, w_new, e1, ch, t1, a0, maj;

	always_comb begin
		s0 = tsn_pkg::rotr(w_q[1], 7) ^ tsn_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = tsn_pkg::rotr(w_q[14], 17) ^ tsn_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		e1 = tsn_pkg::rotr(v_q[4], 6) ^ tsn_pkg::rotr(v_q[4], 11) ^ tsn_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + e1 + ch + tsn_pkg::k_round(ctl.rnd) + w_q[0];
		a0 = tsn_pkg::rotr(v_q[0], 2) ^ tsn_pkg::rotr(v_q[0], 13) ^ tsn_pkg::rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		for (int i = 0; i < 8; i++) begin
			chain_out[255 - 32 * i -: 32] = h_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block_in[511 - 32 * i -: 32];
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_in[255 - 32 * i -: 32];
				h_q[i] <= chain_in[255 - 32 * i -: 32];
			end
		end else if (ctl.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + a0 + maj;
		end else if (ctl.finish) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/triple_sha256_nonce_check.sv =====
// ----------------------------------------------------------------------------
// triple_sha256_nonce_check
// Header/target store, sequencer and compare around one shared round core.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch; every item yields one item on out_ch.
// Loads (operation 0/1) write a header or target word and return an all-zero
// item in the cycle after acceptance. A hash item runs four compressions
// (header block 0, block 1 with the nonce, then two 32-byte rehashes) on
// the single round core; each compression loads, runs 64 rounds and adds
// the working vars into the chain. The next item is taken only after the
// result has been taken from the output register.
// in_ch.ready is low while a hash runs and while a result waits in the
// output register; a stalled receiver holds the result and the block.
// Reset clears the sequencer, the output valid and bench_mode; header and
// target words are undefined until loaded. bench_mode is written via APB
// at address 0, only while idle: a rule for the user, not enforced here.
// ----------------------------------------------------------------------------
`default_nettype none
module triple_sha256_nonce_check (
	input  wire          clk,
	input  wire          arst_n,
	tsn_stream_if.sink   in_ch,
	tsn_stream_if.source out_ch,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [1:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INIT = 5'b00010,
		ST_RND  = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [1:0]  pass_q;
	logic [5:0]  rnd_q;
	logic        bench_q;
	logic [31:0] hdr_q [tsn_pkg::HdrWords];
	logic [31:0] tgt_q [tsn_pkg::TgtWords];
	logic [31:0] nonce_q;
	tsn_pkg::out_item_t out_q;
	logic        out_valid_q;
	tsn_pkg::core_ctl_t ctl;
	logic [255:0] chain_in, chain_out;
	logic [511:0] block_in;
	logic [31:0] hs [8];
	logic        ok;
	tsn_pkg::in_item_t it;

	assign it = in_ch.data;
	assign pready = 1'b1;
	assign prdata = (paddr == tsn_pkg::RegBench) ? {31'd0, bench_q} : 32'd0;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_comb begin
		ctl.init = (state_q == ST_INIT);
		ctl.round = (state_q == ST_RND);
		ctl.finish = (state_q == ST_FIN);
		ctl.rnd = rnd_q;
		block_in = '0;
		chain_in = tsn_pkg::Iv;
		case (pass_q)
			2'd0: begin
				for (int i = 0; i < 16; i++) block_in[511 - 32 * i -: 32] = hdr_q[i];
			end
			2'd1: begin
				block_in[511:384] = {hdr_q[16], hdr_q[17], hdr_q[18], nonce_q};
				block_in[383:352] = tsn_pkg::PadWord;
				block_in[31:0] = tsn_pkg::Len80;
				chain_in = chain_out;
			end
			default: begin
				block_in[511:256] = chain_out;
				block_in[255:224] = tsn_pkg::PadWord;
				block_in[31:0] = tsn_pkg::Len32;
			end
		endcase
		for (int i = 0; i < 8; i++) hs[i] = tsn_pkg::bswap(chain_out[255 - 32 * i -: 32]);
		// compare from word 7 down; first difference decides
		ok = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (hs[i] > tgt_q[i]) ok = 1'b0;
			else if (hs[i] < tgt_q[i]) ok = 1'b1;
		end
	end

	tsn_round_core u_core (
		.clk(clk), .ctl(ctl), .chain_in(chain_in),
		.block_in(block_in), .chain_out(chain_out));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bench_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == tsn_pkg::RegBench) begin
			bench_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			if (it.operation == tsn_pkg::OP_LOAD_HDR && it.word_index < 5'(tsn_pkg::HdrWords))
				hdr_q[it.word_index] <= it.word_value;
			if (it.operation == tsn_pkg::OP_LOAD_TGT && it.word_index < 5'(tsn_pkg::TgtWords))
				tgt_q[it.word_index[2:0]] <= it.word_value;
			nonce_q <= it.nonce;
		end
		if (in_ch.valid && in_ch.ready && it.operation != tsn_pkg::OP_HASH) begin
			out_q <= '0;
		end else if (state_q == ST_OUT) begin
			out_q.meets_target <= ok && !bench_q;
			out_q.nonce_echo <= nonce_q;
			out_q.hash_low_pair <= {hs[1], hs[0]};
			out_q.hash_second_pair <= {hs[3], hs[2]};
			out_q.hash_third_pair <= {hs[5], hs[4]};
			out_q.hash_high_pair <= {hs[7], hs[6]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= 2'd0;
			rnd_q <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (it.operation == tsn_pkg::OP_HASH) begin
							state_q <= ST_INIT;
							pass_q <= 2'd0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_INIT: begin
					rnd_q <= 6'd0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (pass_q == 2'd3) begin
						state_q <= ST_OUT;
					end else begin
						pass_q <= pass_q + 2'd1;
						state_q <= ST_INIT;
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/tsn_checker.sv =====
// ----------------------------------------------------------------------------
// tsn_checker
// Port-level checks on the nonce check block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triple_sha256_nonce_check_assert.svh"
module tsn_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire pready
);
	`TSN_ASSERT_IMP(a_no_in_while_out, arst_n, out_valid, !in_ready)
	`TSN_ASSERT_NXT(a_out_holds, arst_n, out_valid && !out_ready, out_valid)
	`TSN_ASSERT_NXT(a_out_clears, arst_n, out_valid && out_ready, !out_valid)
	`TSN_ASSERT_IMP(a_pready, arst_n, 1'b1, pready)
endmodule

bind triple_sha256_nonce_check tsn_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .pready(pready));
`default_nettype wire
